/* design/crtc_pkg.sv */
// Shared types and constants for the CRT timing controller.
package crtc_pkg;

  // Bus operation carried by each input transfer.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SELECT = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Register numbers, 6845 layout.
  localparam logic [4:0] REG_HTOTAL     = 5'd0;
  localparam logic [4:0] REG_HDISP      = 5'd1;
  localparam logic [4:0] REG_HSYNC_POS  = 5'd2;
  localparam logic [4:0] REG_SYNC_WIDTH = 5'd3;
  localparam logic [4:0] REG_VTOTAL     = 5'd4;
  localparam logic [4:0] REG_VDISP      = 5'd6;
  localparam logic [4:0] REG_VSYNC_POS  = 5'd7;
  localparam logic [4:0] REG_MODE       = 5'd8;
  localparam logic [4:0] REG_MAX_SCAN   = 5'd9;
  localparam logic [4:0] REG_CUR_START  = 5'd10;
  localparam logic [4:0] REG_CUR_END    = 5'd11;
  localparam logic [4:0] REG_START_HI   = 5'd12;
  localparam logic [4:0] REG_START_LO   = 5'd13;
  localparam logic [4:0] REG_CUR_HI     = 5'd14;
  localparam logic [4:0] REG_CUR_LO     = 5'd15;

  localparam logic [7:0] MODE_MASK      = 8'hf3;
  localparam logic [1:0] INTERLACE_VID  = 2'b11;
  localparam logic [1:0] SKEW_NEVER     = 2'd3;
  localparam logic [1:0] CURSOR_NONE    = 2'b01;
  localparam logic [2:0] DELAY_EXPIRED  = 3'd7;

  // Pending flag bit positions.
  localparam int PF_CSTART = 0;
  localparam int PF_CON    = 1;
  localparam int PF_EN     = 2;
  localparam int PF_DIS    = 3;

  // Enable tracking bundle: enable bits, pending flags and the two delays.
  typedef struct packed {
    logic [2:0] bits;
    logic [3:0] pend;
    logic [2:0] en_dly;
    logic [2:0] dis_dly;
  } en_state_t;

endpackage

/* design/crtc_in_if.sv */
// Input channel: bus operation and data byte.
interface crtc_in_if;
  logic           valid;
  logic           ready;
  crtc_pkg::op_t  opcode;
  logic [7:0]     bus_data;

  modport source (output valid, output opcode, output bus_data, input ready);
  modport sink   (input valid, input opcode, input bus_data, output ready);
endinterface

/* design/crtc_out_if.sv */
// Output channel: read data and raster timing outputs.
interface crtc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [13:0] refresh_address;
  logic [4:0]  row_address;
  logic        hsync;
  logic        vsync;
  logic        display_enable;
  logic        cursor_on;

  modport source (output valid, output read_data, output refresh_address,
                  output row_address, output hsync, output vsync,
                  output display_enable, output cursor_on, input ready);
  modport sink   (input valid, input read_data, input refresh_address,
                  input row_address, input hsync, input vsync,
                  input display_enable, input cursor_on, output ready);
endinterface

/* design/crt_controller_timing_unit.sv */
// Top level of the CRT timing controller: registers, counters and result register.
//
//  channel  | dir | payload                                        | transfer when
//  ---------+-----+------------------------------------------------+---------------
//  in_ch    | in  | opcode, bus_data                               | valid & ready
//  out_ch   | out | read_data, refresh_address, row_address,       | valid & ready
//           |     | hsync, vsync, display_enable, cursor_on        |
//
//  The whole tick or bus operation is evaluated in one combinational pass
//  from the state registers and the incoming transfer, and lands in the
//  state registers and the result register at the accepting edge.
//  An item can be taken every cycle. in_ch.ready is high while the result
//  register is empty or being drained, so a stalled sink holds one result
//  and blocks new input. Synchronous reset clears the state registers and
//  result valid; the wrap flags come out of reset set.
module crt_controller_timing_unit (
  input  logic              clk,
  input  logic              rst,
  crtc_in_if.sink           in_ch,
  crtc_out_if.source        out_ch
);

  // Programmed registers
  logic [4:0]  register_select, register_select_next;
  logic [7:0]  horiz_total, horiz_total_next;
  logic [7:0]  horiz_displayed, horiz_displayed_next;
  logic [7:0]  hsync_position, hsync_position_next;
  logic [7:0]  sync_widths, sync_widths_next;
  logic [6:0]  vert_total, vert_total_next;
  logic [6:0]  vert_displayed, vert_displayed_next;
  logic [6:0]  vsync_position, vsync_position_next;
  logic [7:0]  mode_and_skew, mode_and_skew_next;
  logic [4:0]  max_scan_line, max_scan_line_next;
  logic [6:0]  cursor_start_reg, cursor_start_reg_next;
  logic [4:0]  cursor_end_reg, cursor_end_reg_next;
  logic [13:0] start_address, start_address_next;
  logic [13:0] cursor_position, cursor_position_next;

  // Raster counters and sync state
  logic [7:0]  horiz_count, horiz_count_next;
  logic [4:0]  scan_count, scan_count_next;
  logic [6:0]  row_count, row_count_next;
  logic [3:0]  hsync_width_count, hsync_width_count_next;
  logic [3:0]  vsync_width_count, vsync_width_count_next;
  logic        hsync_flag, hsync_flag_next;
  logic        vsync_flag, vsync_flag_next;
  logic [2:0]  wrap_pending, wrap_pending_next;   // bit0 horiz, bit1 scan, bit2 row
  logic [13:0] address_counter, address_counter_next;
  logic [13:0] next_row_address, next_row_address_next;
  logic [13:0] row_start_address, row_start_address_next;

  // Enable / cursor skew pipeline
  crtc_pkg::en_state_t en_state, en_state_next;
  logic        display_out, display_out_next;
  logic        cursor_out, cursor_out_next;
  logic [2:0]  cursor_delay, cursor_delay_next;

  logic [7:0]  read_data_next;
  logic [4:0]  scan_inc;
  logic [1:0]  disp_skew;
  logic [1:0]  cur_skew;

  // Result register
  logic        res_valid;
  logic [7:0]  res_read_data;
  logic [13:0] res_refresh_address;
  logic [4:0]  res_row_address;
  logic        res_hsync;
  logic        res_vsync;
  logic        res_display_enable;
  logic        res_cursor_on;

  logic        accept;

  // Count down one tick; sticks at expired until reloaded.
  function automatic logic [2:0] count_down(logic [2:0] d);
    logic [2:0] r;
    r = d;
    if (d != crtc_pkg::DELAY_EXPIRED) begin
      r = (d == 3'd0) ? crtc_pkg::DELAY_EXPIRED : d - 3'd1;
    end
    return r;
  endfunction

  // Set or clear one enable bit, then track edges of the combined enable.
  function automatic crtc_pkg::en_state_t set_enable(crtc_pkg::en_state_t s,
                                                     logic [2:0] mask, logic on,
                                                     logic [1:0] skew);
    crtc_pkg::en_state_t r;
    logic nx;
    logic cur;
    r = s;
    if (on) r.bits = r.bits | mask;
    else    r.bits = r.bits & ~mask;
    nx  = r.bits[0] & r.bits[1];
    cur = r.bits[2];
    if (nx && !cur) begin
      r.en_dly = {1'b0, skew};
      if (skew != crtc_pkg::SKEW_NEVER) r.pend[crtc_pkg::PF_EN] = 1'b1;
    end
    if (!nx && cur) begin
      r.dis_dly = {1'b0, skew};
      r.pend[crtc_pkg::PF_DIS] = 1'b1;
    end
    r.bits[2] = nx;
    return r;
  endfunction

  assign accept      = in_ch.valid & in_ch.ready;
  assign in_ch.ready = ~res_valid | out_ch.ready;

  assign scan_inc  = (mode_and_skew[1:0] == crtc_pkg::INTERLACE_VID) ? 5'd2 : 5'd1;
  assign disp_skew = mode_and_skew[5:4];
  assign cur_skew  = mode_and_skew[7:6];

  // One item, evaluated in program order of the raster update.
  always_comb begin
    register_select_next   = register_select;
    horiz_total_next       = horiz_total;
    horiz_displayed_next   = horiz_displayed;
    hsync_position_next    = hsync_position;
    sync_widths_next       = sync_widths;
    vert_total_next        = vert_total;
    vert_displayed_next    = vert_displayed;
    vsync_position_next    = vsync_position;
    mode_and_skew_next     = mode_and_skew;
    max_scan_line_next     = max_scan_line;
    cursor_start_reg_next  = cursor_start_reg;
    cursor_end_reg_next    = cursor_end_reg;
    start_address_next     = start_address;
    cursor_position_next   = cursor_position;
    horiz_count_next       = horiz_count;
    scan_count_next        = scan_count;
    row_count_next         = row_count;
    hsync_width_count_next = hsync_width_count;
    vsync_width_count_next = vsync_width_count;
    hsync_flag_next        = hsync_flag;
    vsync_flag_next        = vsync_flag;
    wrap_pending_next      = wrap_pending;
    address_counter_next   = address_counter;
    next_row_address_next  = next_row_address;
    row_start_address_next = row_start_address;
    en_state_next          = en_state;
    display_out_next       = display_out;
    cursor_out_next        = cursor_out;
    cursor_delay_next      = cursor_delay;
    read_data_next         = 8'd0;

    unique case (in_ch.opcode)
      crtc_pkg::OP_TICK: begin
        address_counter_next = address_counter + 14'd1;
        horiz_count_next     = horiz_count + 8'd1;

        // End of a character line
        if (wrap_pending_next[0]) begin
          horiz_count_next     = 8'd0;
          wrap_pending_next[0] = 1'b0;
          en_state_next        = set_enable(en_state_next, 3'b001, 1'b1, disp_skew);
          address_counter_next = row_start_address_next;
          scan_count_next      = scan_count + scan_inc;

          // End of a character row
          if (wrap_pending_next[1]) begin
            scan_count_next        = 5'd0;
            wrap_pending_next[1]   = 1'b0;
            row_start_address_next = next_row_address_next;
            address_counter_next   = row_start_address_next;
            row_count_next         = row_count + 7'd1;

            // End of frame
            if (wrap_pending_next[2]) begin
              row_count_next         = 7'd0;
              wrap_pending_next[2]   = 1'b0;
              en_state_next          = set_enable(en_state_next, 3'b010, 1'b1, disp_skew);
              row_start_address_next = start_address;
              address_counter_next   = row_start_address_next;
            end
            if (row_count_next >= vert_total) wrap_pending_next[2] = 1'b1;
            if (row_count_next == vert_displayed) begin
              en_state_next = set_enable(en_state_next, 3'b010, 1'b0, disp_skew);
            end
            if (vsync_flag_next) vsync_width_count_next = vsync_width_count_next + 4'd1;
            if (row_count_next == vsync_position) vsync_flag_next = 1'b1;
            if (vsync_width_count_next >= sync_widths[7:4]) begin
              vsync_width_count_next = 4'd0;
              vsync_flag_next        = 1'b0;
            end
          end
          if (scan_count_next >= max_scan_line) wrap_pending_next[1] = 1'b1;
        end

        if (horiz_count_next >= horiz_total) wrap_pending_next[0] = 1'b1;
        if (horiz_count_next == horiz_displayed) begin
          next_row_address_next = address_counter_next;
          en_state_next = set_enable(en_state_next, 3'b001, 1'b0, disp_skew);
        end
        if (hsync_flag_next) hsync_width_count_next = hsync_width_count_next + 4'd1;
        if (horiz_count_next == hsync_position) hsync_flag_next = 1'b1;
        if (hsync_width_count_next >= sync_widths[3:0]) begin
          hsync_width_count_next = 4'd0;
          hsync_flag_next        = 1'b0;
        end

        // Cursor window hit
        if (address_counter_next == cursor_position &&
            scan_count_next >= cursor_start_reg[4:0] &&
            scan_count_next <= cursor_end_reg && en_state_next.bits[2]) begin
          cursor_delay_next = {1'b0, cur_skew};
          if (cur_skew != crtc_pkg::SKEW_NEVER) en_state_next.pend[crtc_pkg::PF_CSTART] = 1'b1;
        end

        // Cursor pulse lasts one tick
        if (en_state_next.pend[crtc_pkg::PF_CON]) begin
          en_state_next.pend[crtc_pkg::PF_CON] = 1'b0;
          cursor_out_next = 1'b0;
        end
        if (en_state_next.pend[crtc_pkg::PF_CSTART]) begin
          cursor_delay_next = count_down(cursor_delay_next);
          if (cursor_delay_next == crtc_pkg::DELAY_EXPIRED &&
              cursor_start_reg[6:5] != crtc_pkg::CURSOR_NONE) begin
            en_state_next.pend[crtc_pkg::PF_CSTART] = 1'b0;
            en_state_next.pend[crtc_pkg::PF_CON]    = 1'b1;
            cursor_out_next = 1'b1;
          end
        end
        if (en_state_next.pend[crtc_pkg::PF_EN]) begin
          en_state_next.en_dly = count_down(en_state_next.en_dly);
          if (en_state_next.en_dly == crtc_pkg::DELAY_EXPIRED) begin
            en_state_next.pend[crtc_pkg::PF_EN] = 1'b0;
            display_out_next = 1'b1;
          end
        end
        if (en_state_next.pend[crtc_pkg::PF_DIS]) begin
          en_state_next.dis_dly = count_down(en_state_next.dis_dly);
          if (en_state_next.dis_dly == crtc_pkg::DELAY_EXPIRED) begin
            en_state_next.pend[crtc_pkg::PF_DIS] = 1'b0;
            display_out_next = 1'b0;
          end
        end
      end

      crtc_pkg::OP_SELECT: begin
        register_select_next = in_ch.bus_data[4:0];
      end

      crtc_pkg::OP_WRITE: begin
        unique case (register_select)
          crtc_pkg::REG_HTOTAL:     horiz_total_next      = in_ch.bus_data;
          crtc_pkg::REG_HDISP:      horiz_displayed_next  = in_ch.bus_data;
          crtc_pkg::REG_HSYNC_POS:  hsync_position_next   = in_ch.bus_data;
          crtc_pkg::REG_SYNC_WIDTH: sync_widths_next      = in_ch.bus_data;
          crtc_pkg::REG_VTOTAL:     vert_total_next       = in_ch.bus_data[6:0];
          crtc_pkg::REG_VDISP:      vert_displayed_next   = in_ch.bus_data[6:0];
          crtc_pkg::REG_VSYNC_POS:  vsync_position_next   = in_ch.bus_data[6:0];
          crtc_pkg::REG_MODE:       mode_and_skew_next    = in_ch.bus_data & crtc_pkg::MODE_MASK;
          crtc_pkg::REG_MAX_SCAN:   max_scan_line_next    = in_ch.bus_data[4:0];
          crtc_pkg::REG_CUR_START:  cursor_start_reg_next = in_ch.bus_data[6:0];
          crtc_pkg::REG_CUR_END:    cursor_end_reg_next   = in_ch.bus_data[4:0];
          crtc_pkg::REG_START_HI:   start_address_next    = {in_ch.bus_data[5:0],
                                                             start_address[7:0]};
          crtc_pkg::REG_START_LO:   start_address_next    = {start_address[13:8],
                                                             in_ch.bus_data};
          crtc_pkg::REG_CUR_HI:     cursor_position_next  = {in_ch.bus_data[5:0],
                                                             cursor_position[7:0]};
          crtc_pkg::REG_CUR_LO:     cursor_position_next  = {cursor_position[13:8],
                                                             in_ch.bus_data};
          default: ;  // vertical adjust, light pen, unused
        endcase
      end

      crtc_pkg::OP_READ: begin
        if (register_select == crtc_pkg::REG_CUR_HI) begin
          read_data_next = {2'b00, cursor_position[13:8]};
        end else if (register_select == crtc_pkg::REG_CUR_LO) begin
          read_data_next = cursor_position[7:0];
        end
      end

      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      register_select   <= '0;
      horiz_total       <= '0;
      horiz_displayed   <= '0;
      hsync_position    <= '0;
      sync_widths       <= '0;
      vert_total        <= '0;
      vert_displayed    <= '0;
      vsync_position    <= '0;
      mode_and_skew     <= '0;
      max_scan_line     <= '0;
      cursor_start_reg  <= '0;
      cursor_end_reg    <= '0;
      start_address     <= '0;
      cursor_position   <= '0;
      horiz_count       <= '0;
      scan_count        <= '0;
      row_count         <= '0;
      hsync_width_count <= '0;
      vsync_width_count <= '0;
      hsync_flag        <= 1'b0;
      vsync_flag        <= 1'b0;
      wrap_pending      <= 3'b111;
      address_counter   <= '0;
      next_row_address  <= '0;
      row_start_address <= '0;
      en_state          <= '0;
      display_out       <= 1'b0;
      cursor_out        <= 1'b0;
      cursor_delay      <= '0;
    end else if (accept) begin
      register_select   <= register_select_next;
      horiz_total       <= horiz_total_next;
      horiz_displayed   <= horiz_displayed_next;
      hsync_position    <= hsync_position_next;
      sync_widths       <= sync_widths_next;
      vert_total        <= vert_total_next;
      vert_displayed    <= vert_displayed_next;
      vsync_position    <= vsync_position_next;
      mode_and_skew     <= mode_and_skew_next;
      max_scan_line     <= max_scan_line_next;
      cursor_start_reg  <= cursor_start_reg_next;
      cursor_end_reg    <= cursor_end_reg_next;
      start_address     <= start_address_next;
      cursor_position   <= cursor_position_next;
      horiz_count       <= horiz_count_next;
      scan_count        <= scan_count_next;
      row_count         <= row_count_next;
      hsync_width_count <= hsync_width_count_next;
      vsync_width_count <= vsync_width_count_next;
      hsync_flag        <= hsync_flag_next;
      vsync_flag        <= vsync_flag_next;
      wrap_pending      <= wrap_pending_next;
      address_counter   <= address_counter_next;
      next_row_address  <= next_row_address_next;
      row_start_address <= row_start_address_next;
      en_state          <= en_state_next;
      display_out       <= display_out_next;
      cursor_out        <= cursor_out_next;
      cursor_delay      <= cursor_delay_next;
    end
  end

  // Result register: valid is control, payload loads on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_read_data       <= read_data_next;
      res_refresh_address <= address_counter_next;
      res_row_address     <= scan_count_next;
      res_hsync           <= hsync_flag_next;
      res_vsync           <= vsync_flag_next;
      res_display_enable  <= display_out_next;
      res_cursor_on       <= cursor_out_next;
    end
  end

  assign out_ch.valid           = res_valid;
  assign out_ch.read_data       = res_read_data;
  assign out_ch.refresh_address = res_refresh_address;
  assign out_ch.row_address     = res_row_address;
  assign out_ch.hsync           = res_hsync;
  assign out_ch.vsync           = res_vsync;
  assign out_ch.display_enable  = res_display_enable;
  assign out_ch.cursor_on       = res_cursor_on;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the CRT timing controller: shadow raster model plus scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register numbers the package leaves unnamed: all of them are ignored on write.
  localparam logic [4:0] REG_VADJUST = 5'd5;
  localparam logic [4:0] REG_PEN_HI  = 5'd16;
  localparam logic [4:0] REG_PEN_LO  = 5'd17;

  localparam int ITEM_TARGET  = 1450;
  localparam int IDLE_LIMIT   = 5000;  // cycles with no transfer on either side
  localparam int HOLD_CYCLES  = 300;   // long sink stall, fills the result register
  localparam int HOLD_AT      = 500;   // result count at which the long stall starts
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;

  // One output transfer, field by field.
  typedef struct packed {
    logic [7:0]  read_data;
    logic [13:0] refresh_address;
    logic [4:0]  row_address;
    logic        hsync;
    logic        vsync;
    logic        display_enable;
    logic        cursor_on;
  } raster_out_t;

  // Shadow of the raster state; predicts the output of every accepted
  // operation and keeps the predictions until the matching output transfer.
  class raster_shadow;
    bit [4:0]  sel;
    bit [7:0]  h_total, h_disp, hs_pos, sync_w, mode;
    bit [6:0]  v_total, v_disp, vs_pos, cur_start;
    bit [4:0]  max_scan, cur_end;
    bit [13:0] start_addr, cur_pos;
    bit [7:0]  hcnt;
    bit [4:0]  scnt;
    bit [6:0]  rcnt;
    bit [3:0]  hs_wc, vs_wc;
    bit        hs_f, vs_f;
    bit [2:0]  wrap;
    bit [13:0] addr, next_row, row_start;
    bit [2:0]  en_bits;
    bit        disp, cur;
    bit [3:0]  pend;
    bit [2:0]  cur_dly, en_dly, dis_dly;
    raster_out_t upcoming[$];
    int mismatches;

    function new();
      sel = 0; h_total = 0; h_disp = 0; hs_pos = 0; sync_w = 0; mode = 0;
      v_total = 0; v_disp = 0; vs_pos = 0; cur_start = 0; max_scan = 0; cur_end = 0;
      start_addr = 0; cur_pos = 0; hcnt = 0; scnt = 0; rcnt = 0;
      hs_wc = 0; vs_wc = 0; hs_f = 0; vs_f = 0;
      wrap = 3'b111;
      addr = 0; next_row = 0; row_start = 0;
      en_bits = 0; disp = 0; cur = 0; pend = 0;
      cur_dly = 0; en_dly = 0; dis_dly = 0;
      mismatches = 0;
    endfunction

    // Down counter that parks at the expired code once it passes zero.
    function bit [2:0] dec_delay(bit [2:0] d);
      if (d == crtc_pkg::DELAY_EXPIRED || d == 3'd0) return crtc_pkg::DELAY_EXPIRED;
      return d - 3'd1;
    endfunction

    function void refresh_enable();
      bit nxt;
      bit [1:0] skew;
      nxt  = en_bits[0] & en_bits[1];
      skew = mode[5:4];
      if (nxt && !en_bits[2]) begin
        en_dly = {1'b0, skew};
        if (skew != crtc_pkg::SKEW_NEVER) pend[crtc_pkg::PF_EN] = 1'b1;
      end
      if (!nxt && en_bits[2]) begin
        dis_dly = {1'b0, skew};
        pend[crtc_pkg::PF_DIS] = 1'b1;
      end
      en_bits[2] = nxt;
    endfunction

    function void set_enable(int idx, bit on);
      en_bits[idx] = on;
      refresh_enable();
    endfunction

    function void write_reg(bit [7:0] v);
      case (sel)
        crtc_pkg::REG_HTOTAL:     h_total = v;
        crtc_pkg::REG_HDISP:      h_disp = v;
        crtc_pkg::REG_HSYNC_POS:  hs_pos = v;
        crtc_pkg::REG_SYNC_WIDTH: sync_w = v;
        crtc_pkg::REG_VTOTAL:     v_total = v[6:0];
        crtc_pkg::REG_VDISP:      v_disp = v[6:0];
        crtc_pkg::REG_VSYNC_POS:  vs_pos = v[6:0];
        crtc_pkg::REG_MODE:       mode = v & crtc_pkg::MODE_MASK;
        crtc_pkg::REG_MAX_SCAN:   max_scan = v[4:0];
        crtc_pkg::REG_CUR_START:  cur_start = v[6:0];
        crtc_pkg::REG_CUR_END:    cur_end = v[4:0];
        crtc_pkg::REG_START_HI:   start_addr[13:8] = v[5:0];
        crtc_pkg::REG_START_LO:   start_addr[7:0] = v;
        crtc_pkg::REG_CUR_HI:     cur_pos[13:8] = v[5:0];
        crtc_pkg::REG_CUR_LO:     cur_pos[7:0] = v;
        default: ;
      endcase
    endfunction

    function void advance_tick();
      bit [4:0] step;
      step = (mode[1:0] == crtc_pkg::INTERLACE_VID) ? 5'd2 : 5'd1;
      addr = addr + 14'd1;
      hcnt = hcnt + 8'd1;
      if (wrap[0]) begin
        hcnt = 0;
        wrap[0] = 1'b0;
        set_enable(0, 1'b1);
        addr = row_start;
        scnt = scnt + step;
        if (wrap[1]) begin
          scnt = 0;
          wrap[1] = 1'b0;
          row_start = next_row;
          addr = row_start;
          rcnt = rcnt + 7'd1;
          if (wrap[2]) begin
            rcnt = 0;
            wrap[2] = 1'b0;
            set_enable(1, 1'b1);
            row_start = start_addr;
            addr = row_start;
          end
          if (rcnt >= v_total) wrap[2] = 1'b1;
          if (rcnt == v_disp) set_enable(1, 1'b0);
          if (vs_f) vs_wc = vs_wc + 4'd1;
          if (rcnt == vs_pos) vs_f = 1'b1;
          if (vs_wc >= sync_w[7:4]) begin
            vs_wc = 0;
            vs_f = 1'b0;
          end
        end
        if (scnt >= max_scan) wrap[1] = 1'b1;
      end
      if (hcnt >= h_total) wrap[0] = 1'b1;
      if (hcnt == h_disp) begin
        next_row = addr;
        set_enable(0, 1'b0);
      end
      if (hs_f) hs_wc = hs_wc + 4'd1;
      if (hcnt == hs_pos) hs_f = 1'b1;
      if (hs_wc >= sync_w[3:0]) begin
        hs_wc = 0;
        hs_f = 1'b0;
      end

      // cursor hit arms the skew counter; skew three never fires
      if (addr == cur_pos && scnt >= cur_start[4:0] && scnt <= cur_end && en_bits[2]) begin
        cur_dly = {1'b0, mode[7:6]};
        if (mode[7:6] != crtc_pkg::SKEW_NEVER) pend[crtc_pkg::PF_CSTART] = 1'b1;
      end
      if (pend[crtc_pkg::PF_CON]) begin
        pend[crtc_pkg::PF_CON] = 1'b0;
        cur = 1'b0;
      end
      if (pend[crtc_pkg::PF_CSTART]) begin
        cur_dly = dec_delay(cur_dly);
        // an expired start waits out the no-cursor mode
        if (cur_dly == crtc_pkg::DELAY_EXPIRED &&
            cur_start[6:5] != crtc_pkg::CURSOR_NONE) begin
          pend[crtc_pkg::PF_CSTART] = 1'b0;
          pend[crtc_pkg::PF_CON] = 1'b1;
          cur = 1'b1;
        end
      end
      if (pend[crtc_pkg::PF_EN]) begin
        en_dly = dec_delay(en_dly);
        if (en_dly == crtc_pkg::DELAY_EXPIRED) begin
          pend[crtc_pkg::PF_EN] = 1'b0;
          disp = 1'b1;
        end
      end
      if (pend[crtc_pkg::PF_DIS]) begin
        dis_dly = dec_delay(dis_dly);
        if (dis_dly == crtc_pkg::DELAY_EXPIRED) begin
          pend[crtc_pkg::PF_DIS] = 1'b0;
          disp = 1'b0;
        end
      end
    endfunction

    // Called at each accepted input transfer.
    function void log_op(crtc_pkg::op_t op, bit [7:0] data);
      raster_out_t r;
      r.read_data = 8'd0;
      case (op)
        crtc_pkg::OP_TICK:   advance_tick();
        crtc_pkg::OP_SELECT: sel = data[4:0];
        crtc_pkg::OP_WRITE:  write_reg(data);
        crtc_pkg::OP_READ: begin
          if (sel == crtc_pkg::REG_CUR_HI) r.read_data = {2'b00, cur_pos[13:8]};
          else if (sel == crtc_pkg::REG_CUR_LO) r.read_data = cur_pos[7:0];
        end
      endcase
      r.refresh_address = addr;
      r.row_address     = scnt;
      r.hsync           = hs_f;
      r.vsync           = vs_f;
      r.display_enable  = disp;
      r.cursor_on       = cur;
      upcoming.push_back(r);
    endfunction

    // Called at each accepted output transfer.
    function void compare(raster_out_t got);
      raster_out_t exp_r;
      if (upcoming.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: output transfer with nothing expected: %p", $realtime, got);
        return;
      end
      exp_r = upcoming.pop_front();
      if (got.read_data !== exp_r.read_data || got.refresh_address !== exp_r.refresh_address ||
          got.row_address !== exp_r.row_address || got.hsync !== exp_r.hsync ||
          got.vsync !== exp_r.vsync || got.display_enable !== exp_r.display_enable ||
          got.cursor_on !== exp_r.cursor_on) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: rd/fa/ra/hs/vs/de/cur exp %h/%h/%h/%b/%b/%b/%b got %h/%h/%h/%b/%b/%b/%b",
                   $realtime, exp_r.read_data, exp_r.refresh_address, exp_r.row_address,
                   exp_r.hsync, exp_r.vsync, exp_r.display_enable, exp_r.cursor_on,
                   got.read_data, got.refresh_address, got.row_address,
                   got.hsync, got.vsync, got.display_enable, got.cursor_on);
      end
    endfunction

    function int pending();
      return upcoming.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  crtc_in_if  in_ch();
  crtc_out_if out_ch();

  crt_controller_timing_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  raster_shadow shadow = new();
  int items_sent;
  int results_seen;
  bit src_steady;   // sender runs back to back while set
  bit snk_steady;   // sink keeps ready high while set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: no transfer on either side for too long ends the run.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Sink side: random stalls, quiet stretches, and one long hold-off that
  // backs the block up so the input side has to stall.
  initial begin
    int gap;
    raster_out_t got;
    out_ch.ready <= 1'b0;
    results_seen = 0;
    snk_steady = 1'b0;
    repeat (11) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_steady = ~snk_steady;
      gap = snk_steady ? 0 : $urandom_range(0, 6);
      if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      // values seen right after the edge are the ones the edge sampled
      do @(posedge clk); while (!out_ch.valid);
      got.read_data       = out_ch.read_data;
      got.refresh_address = out_ch.refresh_address;
      got.row_address     = out_ch.row_address;
      got.hsync           = out_ch.hsync;
      got.vsync           = out_ch.vsync;
      got.display_enable  = out_ch.display_enable;
      got.cursor_on       = out_ch.cursor_on;
      shadow.compare(got);
      results_seen++;
    end
  end

  // One input transfer with a random lead-in gap; returns at the accepting edge.
  task automatic send(crtc_pkg::op_t op, logic [7:0] data);
    int gap;
    if ($urandom_range(0, 39) == 0) src_steady = ~src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.bus_data <= data;
    do @(posedge clk); while (!in_ch.ready);
    shadow.log_op(op, data);
    items_sent++;
  endtask

  task automatic set_reg(logic [4:0] idx, logic [7:0] v);
    // upper select bits are don't-care
    send(crtc_pkg::OP_SELECT, {3'($urandom_range(0, 7)), idx});
    send(crtc_pkg::OP_WRITE, v);
  endtask

  // Random raster setup, a few read-backs, then a run of character ticks
  // with the odd stray bus operation mixed in.
  task automatic run_frame();
    logic [4:0] order[16];
    logic [4:0] tmp;
    logic [7:0] v;
    logic [7:0] ht;
    logic [4:0] ms;
    logic [13:0] sa, cp;
    int j, n;
    ht = ($urandom_range(0, 9) == 0) ? 8'hff : 8'($urandom_range(0, 14));
    ms = ($urandom_range(0, 9) == 0) ? 5'h1f : 5'($urandom_range(0, 7));
    sa = 14'($urandom_range(0, 16383));
    cp = sa + 14'($urandom_range(0, 40));
    for (int i = 0; i < 16; i++) order[i] = 5'(i);
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < 16; i++) begin
      case (order[i])
        crtc_pkg::REG_HTOTAL:     v = ht;
        crtc_pkg::REG_HDISP:      v = 8'($urandom_range(0, ht + 1));
        crtc_pkg::REG_HSYNC_POS:  v = 8'($urandom_range(0, ht + 1));
        crtc_pkg::REG_SYNC_WIDTH: v = 8'($urandom_range(0, 255));
        crtc_pkg::REG_VTOTAL:     v = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 5))};
        crtc_pkg::REG_VDISP:      v = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 6))};
        crtc_pkg::REG_VSYNC_POS:  v = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 6))};
        crtc_pkg::REG_MODE:       v = 8'($urandom_range(0, 255));
        crtc_pkg::REG_MAX_SCAN:   v = {3'($urandom_range(0, 7)), ms};
        crtc_pkg::REG_CUR_START:  v = {3'($urandom_range(0, 7)), 5'($urandom_range(0, ms))};
        crtc_pkg::REG_CUR_END:    v = {3'($urandom_range(0, 7)), 5'($urandom_range(0, ms))};
        crtc_pkg::REG_START_HI:   v = {2'($urandom_range(0, 3)), sa[13:8]};
        crtc_pkg::REG_START_LO:   v = sa[7:0];
        crtc_pkg::REG_CUR_HI:     v = {2'($urandom_range(0, 3)), cp[13:8]};
        crtc_pkg::REG_CUR_LO:     v = cp[7:0];
        default:                  v = 8'($urandom_range(0, 255));  // vertical adjust: dropped
      endcase
      if ($urandom_range(0, 15) != 0) set_reg(order[i], v);
    end
    // read-backs, cursor registers favored
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 1) != 0)
        send(crtc_pkg::OP_SELECT,
             {3'($urandom_range(0, 7)),
              ($urandom_range(0, 1) != 0) ? crtc_pkg::REG_CUR_HI : crtc_pkg::REG_CUR_LO});
      else
        send(crtc_pkg::OP_SELECT, 8'($urandom_range(0, 255)));
      send(crtc_pkg::OP_READ, 8'($urandom_range(0, 255)));
    end
    n = $urandom_range(40, 160);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0)
        send(crtc_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      else
        send(crtc_pkg::OP_TICK, 8'($urandom_range(0, 255)));  // data is ignored on a tick
    end
  endtask

  initial begin
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= crtc_pkg::OP_TICK;
    in_ch.bus_data <= 8'd0;
    items_sent = 0;
    src_steady = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset state, zero sync widths, ignored and unreadable
    // registers, cursor read-back at full width, mode mask with skew three.
    send(crtc_pkg::OP_READ, 8'hff);
    repeat (3) send(crtc_pkg::OP_TICK, 8'h00);
    send(crtc_pkg::OP_SELECT, 8'hff);           // select beyond the register file
    send(crtc_pkg::OP_WRITE, 8'hff);
    send(crtc_pkg::OP_READ, 8'h00);
    set_reg(crtc_pkg::REG_CUR_HI, 8'hff);
    send(crtc_pkg::OP_READ, 8'h00);
    set_reg(crtc_pkg::REG_CUR_LO, 8'hff);
    send(crtc_pkg::OP_READ, 8'h00);
    set_reg(REG_VADJUST, 8'haa);
    send(crtc_pkg::OP_SELECT, {3'b000, REG_PEN_HI});
    send(crtc_pkg::OP_READ, 8'h00);
    set_reg(REG_PEN_LO, 8'h55);
    set_reg(crtc_pkg::REG_MODE, 8'hff);         // interlace video, both skews at three
    send(crtc_pkg::OP_READ, 8'h00);
    repeat (3) send(crtc_pkg::OP_TICK, 8'hff);

    while (items_sent < ITEM_TARGET) run_frame();
    in_ch.valid <= 1'b0;

    // drain: the watchdog catches a result that never comes
    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
